// ===== rtl/gip_pkg.sv =====
// gip_pkg: types, register codes and constants of the ground-to-image projection unit
// used by every module of the unit; no dependencies
`default_nettype none

package gip_pkg;

	localparam int CAMERA_HEIGHT = 6144;
	localparam logic signed [16:0] GROUND_Z = 17'(-CAMERA_HEIGHT);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COS_PITCH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_PITCH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COS_YAW   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW   = 3'd7;

	localparam int QUEUE_DEPTH = 4;

	localparam int NUM_W = 59;
	localparam int DEN_W = 44;
	localparam int QUO_W = 29;

	localparam logic signed [27:0] PIX_MAX = 28'sh7ffffff;
	localparam logic signed [27:0] PIX_MIN = 28'sh8000000;

	typedef struct packed {
		logic signed [23:0] ground_x;
		logic signed [23:0] ground_y;
	} point_t;

	typedef struct packed {
		logic signed [27:0] pixel_u;
		logic signed [27:0] pixel_v;
		logic               zero_divisor;
	} pixel_t;

	typedef struct packed {
		logic        [13:0] focal_x;
		logic        [13:0] focal_y;
		logic        [12:0] center_x;
		logic        [12:0] center_y;
		logic signed [15:0] cos_pitch;
		logic signed [15:0] sin_pitch;
		logic signed [15:0] cos_yaw;
		logic signed [15:0] sin_yaw;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] a00;
		logic signed [31:0] a01;
		logic signed [30:0] a02;
		logic signed [32:0] a10;
		logic signed [32:0] a11;
		logic signed [31:0] a12;
		logic signed [17:0] a20;
		logic signed [17:0] a21;
		logic signed [16:0] a22;
	} coef_t;

	typedef struct packed {
		logic [1:0][NUM_W-1:0] num_mag;
		logic [1:0]            neg;
		logic [DEN_W-1:0]      den_mag;
		logic                  zero;
	} work_t;

endpackage

`default_nettype wire

// ===== rtl/gip_coef.sv =====
// gip_coef: four-stage pipeline that builds the Q14 projection matrix from the registers
// depends on gip_pkg
`default_nettype none

module gip_coef (
	input  wire logic           clk,
	input  wire gip_pkg::cfg_t  cfg,
	output gip_pkg::coef_t      coef
);

	logic signed [30:0] fxc2_s1, fxs2_s1, fys1_s1, fyc1_s1;
	logic signed [31:0] c1s2_s1, c1c2_s1;
	logic signed [29:0] c1cy_s1, s1cx_s1, s1cy_s1;
	logic signed [15:0] s1_s1, s2_s1, c2_s1;
	logic        [12:0] cx_s1;

	logic signed [30:0] fxc2_s2, fxs2_s2, a02_s2;
	logic signed [45:0] m00_s2, m01_s2, inner_s2;
	logic signed [31:0] a12_s2;
	logic signed [17:0] a20_s2, a21_s2;
	logic signed [16:0] a22_s2;
	logic signed [15:0] s2_s2, c2_s2;
	logic signed [31:0] t20, t21;

	logic signed [31:0] a00_s3, a01_s3, a12_s3;
	logic signed [30:0] a02_s3;
	logic signed [37:0] sh_s3, ch_s3;
	logic signed [40:0] sl_s3, cl_s3;
	logic signed [17:0] a20_s3, a21_s3;
	logic signed [16:0] a22_s3;
	logic signed [46:0] t00, t01;

	logic signed [62:0] t10, t11;

	always_comb begin
		t20 = c1s2_s1 + 32'sd8192;
		t21 = c1c2_s1 + 32'sd8192;
		t00 = (47'(fxc2_s2) <<< 14) + 47'(m00_s2) + 47'sd8192;
		t01 = 47'(m01_s2) - (47'(fxs2_s2) <<< 14) + 47'sd8192;
		t10 = (63'(sh_s3) <<< 24) + 63'(sl_s3) + 63'sd134217728;
		t11 = (63'(ch_s3) <<< 24) + 63'(cl_s3) + 63'sd134217728;
	end

	always_ff @(posedge clk) begin
		fxc2_s1 <= $signed({1'b0, cfg.focal_x}) * cfg.cos_yaw;
		fxs2_s1 <= $signed({1'b0, cfg.focal_x}) * cfg.sin_yaw;
		fys1_s1 <= $signed({1'b0, cfg.focal_y}) * cfg.sin_pitch;
		fyc1_s1 <= $signed({1'b0, cfg.focal_y}) * cfg.cos_pitch;
		c1s2_s1 <= cfg.cos_pitch * cfg.sin_yaw;
		c1c2_s1 <= cfg.cos_pitch * cfg.cos_yaw;
		c1cy_s1 <= cfg.cos_pitch * $signed({1'b0, cfg.center_y});
		s1cx_s1 <= cfg.sin_pitch * $signed({1'b0, cfg.center_x});
		s1cy_s1 <= cfg.sin_pitch * $signed({1'b0, cfg.center_y});
		s1_s1   <= cfg.sin_pitch;
		s2_s1   <= cfg.sin_yaw;
		c2_s1   <= cfg.cos_yaw;
		cx_s1   <= cfg.center_x;

		fxc2_s2  <= fxc2_s1;
		fxs2_s2  <= fxs2_s1;
		m00_s2   <= c1s2_s1 * $signed({1'b0, cx_s1});
		m01_s2   <= c1c2_s1 * $signed({1'b0, cx_s1});
		inner_s2 <= 46'(c1cy_s1) - (46'(fys1_s1) <<< 14);
		a12_s2   <= -32'(fyc1_s1) - 32'(s1cy_s1);
		a02_s2   <= -31'(s1cx_s1);
		a20_s2   <= t20[31:14];
		a21_s2   <= t21[31:14];
		a22_s2   <= -17'(s1_s1);
		s2_s2    <= s2_s1;
		c2_s2    <= c2_s1;

		a00_s3 <= t00[45:14];
		a01_s3 <= t01[45:14];
		sh_s3  <= s2_s2 * $signed(inner_s2[45:24]);
		sl_s3  <= s2_s2 * $signed({1'b0, inner_s2[23:0]});
		ch_s3  <= c2_s2 * $signed(inner_s2[45:24]);
		cl_s3  <= c2_s2 * $signed({1'b0, inner_s2[23:0]});
		a02_s3 <= a02_s2;
		a12_s3 <= a12_s2;
		a20_s3 <= a20_s2;
		a21_s3 <= a21_s2;
		a22_s3 <= a22_s2;

		coef.a00 <= a00_s3;
		coef.a01 <= a01_s3;
		coef.a02 <= a02_s3;
		coef.a10 <= t10[60:28];
		coef.a11 <= t11[60:28];
		coef.a12 <= a12_s3;
		coef.a20 <= a20_s3;
		coef.a21 <= a21_s3;
		coef.a22 <= a22_s3;
	end

endmodule

`default_nettype wire

// ===== rtl/gip_front.sv =====
// gip_front: accepts points, forms the three homogeneous components and classifies them
// into magnitudes, quotient signs and the zero-divisor flag; depends on gip_pkg
`default_nettype none

module gip_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire gip_pkg::point_t point,
	input  wire gip_pkg::coef_t  coef,
	output logic                 work_valid,
	output gip_pkg::work_t       work
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	gip_pkg::point_t pt_s1, pt_s2, pt_s3, pt_s4;

	logic signed [55:0] pux_s5, puy_s5;
	logic signed [47:0] puz_s5;
	logic signed [56:0] pvx_s5, pvy_s5;
	logic signed [48:0] pvz_s5;
	logic signed [41:0] pdx_s5, pdy_s5;
	logic signed [33:0] pdz_s5;

	logic signed [57:0] nu_s6;
	logic signed [58:0] nv_s6;
	logic signed [43:0] den_s6;

	logic        [57:0] nu_mag;
	logic        [58:0] nv_mag;
	logic        [43:0] den_mag;

	always_comb begin
		nu_mag  = nu_s6[57] ? 58'(-nu_s6) : 58'(nu_s6);
		nv_mag  = nv_s6[58] ? 59'(-nv_s6) : 59'(nv_s6);
		den_mag = den_s6[43] ? 44'(-den_s6) : 44'(den_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			work_valid <= 1'b0;
		end else begin
			vld_s1     <= accept;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			vld_s6     <= vld_s5;
			work_valid <= vld_s6;
		end
	end

	// delay line lets the matrix pipeline catch up with a fresh register write
	always_ff @(posedge clk) begin
		pt_s1 <= point;
		pt_s2 <= pt_s1;
		pt_s3 <= pt_s2;
		pt_s4 <= pt_s3;

		pux_s5 <= coef.a00 * pt_s4.ground_x;
		puy_s5 <= coef.a01 * pt_s4.ground_y;
		puz_s5 <= coef.a02 * gip_pkg::GROUND_Z;
		pvx_s5 <= coef.a10 * pt_s4.ground_x;
		pvy_s5 <= coef.a11 * pt_s4.ground_y;
		pvz_s5 <= coef.a12 * gip_pkg::GROUND_Z;
		pdx_s5 <= coef.a20 * pt_s4.ground_x;
		pdy_s5 <= coef.a21 * pt_s4.ground_y;
		pdz_s5 <= coef.a22 * gip_pkg::GROUND_Z;

		nu_s6  <= 58'(pux_s5) + 58'(puy_s5) + 58'(puz_s5);
		nv_s6  <= 59'(pvx_s5) + 59'(pvy_s5) + 59'(pvz_s5);
		den_s6 <= 44'(pdx_s5) + 44'(pdy_s5) + 44'(pdz_s5);

		work.num_mag[0] <= {1'b0, nu_mag};
		work.num_mag[1] <= nv_mag;
		work.neg[0]     <= nu_s6[57] ^ den_s6[43];
		work.neg[1]     <= nv_s6[58] ^ den_s6[43];
		work.den_mag    <= den_mag;
		work.zero       <= (den_s6 == 44'sd0);
	end

endmodule

`default_nettype wire

// ===== rtl/gip_queue.sv =====
// gip_queue: short beat queue between the front and the divider back end
// depends on gip_pkg
`default_nettype none

module gip_queue #(
	parameter int DEPTH = gip_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire gip_pkg::work_t push_data,
	output logic                pop_valid,
	output gip_pkg::work_t      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	gip_pkg::work_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign pop = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
			pop_valid <= 1'b0;
		end else begin
			pop_valid <= pop;
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (pop) begin
			pop_data <= mem[rd_ptr_q];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gip_div.sv =====
// gip_div: pipelined restoring divider, one quotient bit per stage, two lanes sharing
// the denominator; rounds to Q8 and saturates; depends on gip_pkg
`default_nettype none

module gip_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire gip_pkg::work_t work,
	output logic                done,
	output gip_pkg::pixel_t     result
);

	localparam int QB = gip_pkg::QUO_W;
	localparam int DW = gip_pkg::DEN_W;
	localparam int NW = gip_pkg::NUM_W;
	localparam int RW = DW + QB;

	logic                    vld_s  [QB+1];
	logic [DW-1:0]           den_s  [QB+1];
	logic [1:0][RW-1:0]      rem_s  [QB+1];
	logic [1:0][QB-1:0]      quo_s  [QB+1];
	logic [1:0]              neg_s  [QB+1];
	logic [1:0]              ovf_s  [QB+1];
	logic                    zero_s [QB+1];

	logic [1:0][QB-1:0]      mag;
	logic [1:0][27:0]        pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		den_s[0]  <= work.den_mag;
		neg_s[0]  <= work.neg;
		zero_s[0] <= work.zero;
		for (int l = 0; l < 2; l++) begin
			rem_s[0][l] <= RW'({work.num_mag[l], 9'd0});
			quo_s[0][l] <= '0;
			ovf_s[0][l] <= ({(DW + 20 - NW)'(0), work.num_mag[l]} >= {work.den_mag, 20'd0});
		end
	end

	for (genvar st = 0; st < QB; st++) begin : g_stage
		localparam int B = QB - 1 - st;
		logic [RW-1:0] dsh;
		logic [1:0]    take;

		always_comb begin
			dsh = RW'(den_s[st]) << B;
			for (int l = 0; l < 2; l++) begin
				take[l] = (rem_s[st][l] >= dsh);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[st+1] <= 1'b0;
			end else begin
				vld_s[st+1] <= vld_s[st];
			end
		end

		always_ff @(posedge clk) begin
			den_s[st+1]  <= den_s[st];
			neg_s[st+1]  <= neg_s[st];
			ovf_s[st+1]  <= ovf_s[st];
			zero_s[st+1] <= zero_s[st];
			for (int l = 0; l < 2; l++) begin
				rem_s[st+1][l] <= take[l] ? rem_s[st][l] - dsh : rem_s[st][l];
				quo_s[st+1][l] <= quo_s[st][l] | (QB'(take[l]) << B);
			end
		end
	end

	// quotient holds 512*n/d; halve with round half up
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic [QB:0] inc;
			inc    = {1'b0, quo_s[QB][l]} + 1'b1;
			mag[l] = inc[QB:1];
			if (ovf_s[QB][l]) begin
				pix[l] = neg_s[QB][l] ? gip_pkg::PIX_MIN : gip_pkg::PIX_MAX;
			end else if (neg_s[QB][l]) begin
				pix[l] = (mag[l] >= QB'(134217728)) ? gip_pkg::PIX_MIN : 28'(-mag[l]);
			end else begin
				pix[l] = (mag[l] > QB'(134217727)) ? gip_pkg::PIX_MAX : mag[l][27:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		result.pixel_u      <= pix[0];
		result.pixel_v      <= pix[1];
		result.zero_divisor <= zero_s[QB];
	end

endmodule

`default_nettype wire

// ===== rtl/ground_to_image_projection_unit.sv =====
// ground_to_image_projection_unit: top level, register file, matrix pipeline, front,
// queue and divider back end; depends on gip_pkg and all gip_* modules
//
// Projects one ground point (Q12.12 m, at minus the camera height) to a Q20.8 pixel.
// A point is taken on every clock edge with start high; busy is never raised. Each
// result appears on result with done high for one cycle, in order, one per cycle at full
// rate. The receiver cannot stall: results must be captured when done is high. Results
// pass through the front, the queue and the 29-stage divider. Registers must be written
// through cfg_we/cfg_index/cfg_data by the user only while no point is in flight; the
// block itself does not enforce this. A point may follow on the very next cycle.
`default_nettype none

module ground_to_image_projection_unit #(
	parameter int QUEUE_DEPTH = gip_pkg::QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire gip_pkg::point_t                  point,
	output logic                                  busy,
	output logic                                  done,
	output gip_pkg::pixel_t                       result,
	input  wire logic                             cfg_we,
	input  wire logic [gip_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gip_pkg::CFG_DATA_W-1:0]   cfg_data
);

	gip_pkg::cfg_t  cfg_q;
	gip_pkg::coef_t coef;
	gip_pkg::work_t front_work, back_work;
	logic           front_valid, back_valid;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x   <= 14'd1024;
			cfg_q.focal_y   <= 14'd1024;
			cfg_q.center_x  <= 13'd512;
			cfg_q.center_y  <= 13'd256;
			cfg_q.cos_pitch <= 16'sd16384;
			cfg_q.sin_pitch <= 16'sd0;
			cfg_q.cos_yaw   <= 16'sd16384;
			cfg_q.sin_yaw   <= 16'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gip_pkg::REG_FOCAL_X:   cfg_q.focal_x   <= cfg_data[13:0];
				gip_pkg::REG_FOCAL_Y:   cfg_q.focal_y   <= cfg_data[13:0];
				gip_pkg::REG_CENTER_X:  cfg_q.center_x  <= cfg_data[12:0];
				gip_pkg::REG_CENTER_Y:  cfg_q.center_y  <= cfg_data[12:0];
				gip_pkg::REG_COS_PITCH: cfg_q.cos_pitch <= cfg_data;
				gip_pkg::REG_SIN_PITCH: cfg_q.sin_pitch <= cfg_data;
				gip_pkg::REG_COS_YAW:   cfg_q.cos_yaw   <= cfg_data;
				gip_pkg::REG_SIN_YAW:   cfg_q.sin_yaw   <= cfg_data;
				default: ;
			endcase
		end
	end

	gip_coef u_coef (
		.clk  (clk),
		.cfg  (cfg_q),
		.coef (coef)
	);

	gip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (start & ~busy),
		.point      (point),
		.coef       (coef),
		.work_valid (front_valid),
		.work       (front_work)
	);

	gip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_work),
		.pop_valid (back_valid),
		.pop_data  (back_work)
	);

	gip_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (back_valid),
		.work     (back_work),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== test/gip_checker.sv =====
// gip_checker: watches point and pixel beats of the projection unit, predicts each pixel
// and compares; depends on gip_pkg
`timescale 1ns / 100ps

module gip_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  gip_pkg::point_t                point,
	input  logic                           done,
	input  gip_pkg::pixel_t                result,
	input  logic                           cfg_we,
	input  logic [gip_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gip_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import gip_pkg::*;

	cfg_t camera;
	pixel_t expected_pixels[$];

	function automatic longint round_q(longint v, int k);
		longint t;
		t = v + (64'sd1 <<< (k - 1));
		return t >>> k;
	endfunction

	function automatic logic signed [27:0] divide_q8(longint num, longint den);
		logic neg;
		longint n, d, q, r, mag;
		neg = (num < 0) != (den < 0);
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = n / d;
		r = n % d;
		if (q >= (64'sd1 <<< 20))
			return neg ? PIX_MIN : PIX_MAX;
		mag = q * 256 + (r * 512 + d) / (2 * d);
		if (neg)
			return mag >= 134217728 ? PIX_MIN : 28'(-mag);
		return mag > 134217727 ? PIX_MAX : 28'(mag);
	endfunction

	function automatic pixel_t project_point(cfg_t c, point_t p);
		longint fx, fy, cx, cy, c1, s1, c2, s2, x, y, z, inner;
		longint a00, a01, a02, a10, a11, a12, a20, a21, a22, nu, nv, den;
		pixel_t px;
		fx = c.focal_x; fy = c.focal_y; cx = c.center_x; cy = c.center_y;
		c1 = c.cos_pitch; s1 = c.sin_pitch; c2 = c.cos_yaw; s2 = c.sin_yaw;
		x = p.ground_x; y = p.ground_y; z = -CAMERA_HEIGHT;
		a00 = round_q(fx * c2 * 16384 + c1 * s2 * cx, 14);
		a01 = round_q(-fx * s2 * 16384 + c1 * c2 * cx, 14);
		a02 = -s1 * cx;
		inner = -fy * s1 * 16384 + c1 * cy;
		a10 = round_q(s2 * inner, 28);
		a11 = round_q(c2 * inner, 28);
		a12 = -fy * c1 - s1 * cy;
		a20 = round_q(c1 * s2, 14);
		a21 = round_q(c1 * c2, 14);
		a22 = -s1;
		nu = a00 * x + a01 * y + a02 * z;
		nv = a10 * x + a11 * y + a12 * z;
		den = a20 * x + a21 * y + a22 * z;
		px.zero_divisor = den == 0;
		if (den == 0) begin
			px.pixel_u = nu < 0 ? PIX_MIN : PIX_MAX;
			px.pixel_v = nv < 0 ? PIX_MIN : PIX_MAX;
		end else begin
			px.pixel_u = divide_q8(nu, den);
			px.pixel_v = divide_q8(nv, den);
		end
		return px;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = expected_pixels.size();

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			camera <= '{1024, 1024, 512, 256, 16384, 0, 16384, 0};
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FOCAL_X:   camera.focal_x <= cfg_data[13:0];
					REG_FOCAL_Y:   camera.focal_y <= cfg_data[13:0];
					REG_CENTER_X:  camera.center_x <= cfg_data[12:0];
					REG_CENTER_Y:  camera.center_y <= cfg_data[12:0];
					REG_COS_PITCH: camera.cos_pitch <= cfg_data;
					REG_SIN_PITCH: camera.sin_pitch <= cfg_data;
					REG_COS_YAW:   camera.cos_yaw <= cfg_data;
					REG_SIN_YAW:   camera.sin_yaw <= cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (result.pixel_u !== want.pixel_u)
						report_mismatch("pixel_u", result.pixel_u, want.pixel_u);
					if (result.pixel_v !== want.pixel_v)
						report_mismatch("pixel_v", result.pixel_v, want.pixel_v);
					if (result.zero_divisor !== want.zero_divisor)
						report_mismatch("zero_divisor", result.zero_divisor,
							want.zero_divisor);
				end
			end
			if (start && !busy)
				expected_pixels.push_back(project_point(camera, point));
		end
	end
endmodule

// ===== test/testbench.sv =====
// testbench: drives points and register writes into ground_to_image_projection_unit
// and gives the verdict; depends on gip_pkg and gip_checker
`timescale 1ns / 100ps

module testbench;
	import gip_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	point_t point = '0;
	logic busy, done;
	pixel_t result;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int errors, pending;

	ground_to_image_projection_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .point(point), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gip_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// start stays high across back-to-back beats and drops only for a gap
	task automatic send_point(logic signed [23:0] gx, logic signed [23:0] gy, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		point <= '{gx, gy};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain;
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic write_camera(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
			logic [15:0] cy, logic [15:0] cp, logic [15:0] sp, logic [15:0] cw,
			logic [15:0] sw);
		drain();
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_COS_PITCH, cp);
		write_reg(REG_SIN_PITCH, sp);
		write_reg(REG_COS_YAW, cw);
		write_reg(REG_SIN_YAW, sw);
		cfg_we <= 0;
	endtask

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'sd0 + $signed(13'($urandom));
			2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			default: return 24'($signed(17'($urandom)));
		endcase
	endfunction

	function automatic logic [15:0] rand_trig();
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		return 16'($signed(32'($urandom_range(0, 32768)) - 16384));
	endfunction

	initial begin
		int phase;
		bit burst;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset camera, extremes, zero divisor
		send_point(24'sd0, 24'sd0, 1'b0);
		send_point(24'sh7fffff, 24'sh7fffff, 1'b1);
		send_point(24'sh800000, 24'sh800000, 1'b1);
		send_point(24'sh7fffff, 24'sh800000, 1'b0);
		send_point(24'sd4096, 24'sd40960, 1'b0);
		send_point(-24'sd4096, 24'sd4096, 1'b1);
		send_point(24'sd0, 24'sd1, 1'b0);
		send_point(24'sd0, -24'sd1, 1'b0);
		write_camera(16'd16383, 16'd16383, 16'd8191, 16'd8191, 16'h8000, 16'h7fff,
			16'hc000, 16'h4000);
		send_point(24'sd0, 24'sd0, 1'b0);
		send_point(24'sh7fffff, 24'sh800000, 1'b1);
		send_point(24'sh800000, 24'sh7fffff, 1'b1);
		send_point(24'sd4096, 24'sd4096, 1'b0);
		write_camera(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_point(24'sd0, 24'sd0, 1'b0);
		send_point(24'sh7fffff, 24'sh7fffff, 1'b0);
		write_camera(16'd1, 16'd1, 16'd0, 16'd0, 16'd16384, 16'hc000, 16'd16384, 16'd16384);
		send_point(24'sd0, 24'sd0, 1'b0);
		send_point(24'sd12345, -24'sd99999, 1'b1);
		send_point(24'sh800000, 24'sd0, 1'b0);

		for (phase = 0; phase < 10; phase++) begin
			write_camera(16'($urandom_range(1, 16383)), 16'($urandom_range(1, 16383)),
				16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
				rand_trig(), rand_trig(), rand_trig(), rand_trig());
			if (phase == 9)
				write_camera(16'd1024, 16'd1024, 16'd512, 16'd256, 16'd16384, 16'd0,
					16'd16384, 16'd0);
			for (int i = 0; i < 183; i++) begin
				burst = (i / 30) % 2 == 1;
				send_point(rand_coord(), rand_coord(), burst);
			end
		end
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end
endmodule
